/* rtl/dpspm_pkg.sv */
`timescale 1ns / 1ps

package dpspm_pkg;

	// Sample width is fixed by the payload structs.
	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS_DEF = 8;
	localparam int RATIO_FRAC = 8;
	localparam int RATIO_BITS = 16;
	localparam int FULL_SCALE = 100;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_BITS = 16;
	localparam int OUT_MAX = 32767;
	localparam int OUT_MIN = -32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSOR_A_LOW = 3'd0,
		REG_SENSOR_A_HIGH = 3'd1,
		REG_SENSOR_B_LOW = 3'd2,
		REG_SENSOR_B_HIGH = 3'd3,
		REG_WINDOW_LOW = 3'd4,
		REG_WINDOW_HIGH = 3'd5,
		REG_RATIO_LOW = 3'd6,
		REG_RATIO_HIGH = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] reading_a;
		logic [SAMPLE_BITS-1:0] reading_b;
	} in_beat_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] throttle_pct;
		logic agreement;
	} out_beat_t;

endpackage

/* rtl/dual_pedal_sensor_plausibility_map.sv */
`timescale 1ns / 1ps
// Depth: FRAC_BITS + SAMPLE_BITS + 11 register stages from input beat to output beat;
// the restoring divider takes one stage per quotient bit and accounts for most of them.
// Throughput: one sensor pair per cycle while out_ready is high; every stage holds one
// beat and a stall only holds the stages that are full.
// Reset: arst_n clears all valid bits and loads the configuration reset values.
module dual_pedal_sensor_plausibility_map #(
	parameter int FRAC_BITS = dpspm_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dpspm_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [dpspm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  dpspm_pkg::in_beat_t                   in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output dpspm_pkg::out_beat_t                  out_data
);
	import dpspm_pkg::*;

	localparam int SB = SAMPLE_BITS;
	// Quotient magnitude bits: |r - low| * 100 * 2^FRAC_BITS, with 100 < 2^7.
	localparam int QB = SB + 7 + FRAC_BITS;
	// Two front stages, one stage per quotient bit, sign fix, and the output stage with the mean.
	localparam int NST = QB + 4;
	localparam int PW = RATIO_BITS + SB;
	localparam logic signed [QB+1:0] SUM_MAX = (QB+2)'(OUT_MAX);
	localparam logic signed [QB+1:0] SUM_MIN = (QB+2)'(OUT_MIN);

	// Configuration registers. The user must change them only while the pipeline
	// is empty, which the block does not enforce; the first stage reads them directly.
	logic [SB-1:0] a_lo_q, a_hi_q, b_lo_q, b_hi_q, win_lo_q, win_hi_q;
	logic [RATIO_BITS-1:0] rat_lo_q, rat_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_lo_q <= '0;
			a_hi_q <= '1;
			b_lo_q <= '0;
			b_hi_q <= '1;
			win_lo_q <= '0;
			win_hi_q <= '1;
			rat_lo_q <= '0;
			rat_hi_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_SENSOR_A_LOW:  a_lo_q <= cfg_wdata[SB-1:0];
				REG_SENSOR_A_HIGH: a_hi_q <= cfg_wdata[SB-1:0];
				REG_SENSOR_B_LOW:  b_lo_q <= cfg_wdata[SB-1:0];
				REG_SENSOR_B_HIGH: b_hi_q <= cfg_wdata[SB-1:0];
				REG_WINDOW_LOW:    win_lo_q <= cfg_wdata[SB-1:0];
				REG_WINDOW_HIGH:   win_hi_q <= cfg_wdata[SB-1:0];
				REG_RATIO_LOW:     rat_lo_q <= cfg_wdata[RATIO_BITS-1:0];
				REG_RATIO_HIGH:    rat_hi_q <= cfg_wdata[RATIO_BITS-1:0];
			endcase
		end
	end

	// Flow control. Each stage may load when it is empty or when the stage after
	// it moves on, so a bubble anywhere downstream lets a new beat in even while a
	// finished result waits at the output.
	logic [NST-1:0] vld_s;
	logic [NST:0] en;

	assign en[NST] = out_ready;
	for (genvar k = 0; k < NST; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign in_ready = en[0];

	// Stage 1: offsets from the span start, span lengths, window checks and the
	// two ratio products. Differences are kept as SB+1 bit two's complement.
	logic [SB:0] dif_a_s1, dif_b_s1, spn_a_s1, spn_b_s1;
	logic win_ok_s1, span_ok_s1, b_nz_s1;
	logic [PW-1:0] prod_lo_s1, prod_hi_s1;
	logic [SB-1:0] a_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dif_a_s1 <= {1'b0, in_data.reading_a} - {1'b0, a_lo_q};
			dif_b_s1 <= {1'b0, in_data.reading_b} - {1'b0, b_lo_q};
			spn_a_s1 <= {1'b0, a_hi_q} - {1'b0, a_lo_q};
			spn_b_s1 <= {1'b0, b_hi_q} - {1'b0, b_lo_q};
			win_ok_s1 <= (win_lo_q < in_data.reading_a) && (in_data.reading_a < win_hi_q)
				&& (win_lo_q < in_data.reading_b) && (in_data.reading_b < win_hi_q);
			span_ok_s1 <= (a_hi_q != a_lo_q) && (b_hi_q != b_lo_q);
			b_nz_s1 <= (in_data.reading_b != '0);
			prod_lo_s1 <= PW'(rat_lo_q) * PW'(in_data.reading_b);
			prod_hi_s1 <= PW'(rat_hi_q) * PW'(in_data.reading_b);
			a_s1 <= in_data.reading_a;
		end
	end

	// Stage 2: the ratio compare finishes the agreement decision; offsets and
	// spans turn into magnitudes plus a quotient sign for the divider.
	logic [SB:0] abs_a_c, abs_b_c, asp_a_c, asp_b_c;
	logic [PW-1:0] a_scl_c;
	logic agree_s2, neg_a_s2, neg_b_s2;
	logic [QB-1:0] num_a_s2, num_b_s2;
	logic [SB-1:0] dvs_a_s2, dvs_b_s2;

	always_comb begin
		abs_a_c = dif_a_s1[SB] ? (~dif_a_s1 + 1'b1) : dif_a_s1;
		abs_b_c = dif_b_s1[SB] ? (~dif_b_s1 + 1'b1) : dif_b_s1;
		asp_a_c = spn_a_s1[SB] ? (~spn_a_s1 + 1'b1) : spn_a_s1;
		asp_b_c = spn_b_s1[SB] ? (~spn_b_s1 + 1'b1) : spn_b_s1;
		a_scl_c = PW'(a_s1) << RATIO_FRAC;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			agree_s2 <= span_ok_s1 && win_ok_s1 && b_nz_s1
				&& (prod_lo_s1 < a_scl_c) && (a_scl_c < prod_hi_s1);
			num_a_s2 <= (QB'(abs_a_c[SB-1:0]) * QB'(FULL_SCALE)) << FRAC_BITS;
			num_b_s2 <= (QB'(abs_b_c[SB-1:0]) * QB'(FULL_SCALE)) << FRAC_BITS;
			dvs_a_s2 <= asp_a_c[SB-1:0];
			dvs_b_s2 <= asp_b_c[SB-1:0];
			neg_a_s2 <= dif_a_s1[SB] ^ spn_a_s1[SB];
			neg_b_s2 <= dif_b_s1[SB] ^ spn_b_s1[SB];
		end
	end

	// Restoring divider, one quotient bit per stage for both channels. The
	// numerator word shifts left and the quotient bits fill in from the bottom.
	logic [SB-1:0] rem_a_s [QB];
	logic [SB-1:0] rem_b_s [QB];
	logic [QB-1:0] num_a_s [QB];
	logic [QB-1:0] num_b_s [QB];
	logic [SB-1:0] dvs_a_s [QB];
	logic [SB-1:0] dvs_b_s [QB];
	logic neg_a_s [QB];
	logic neg_b_s [QB];
	logic agree_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [SB-1:0] rin_a, rin_b, din_a, din_b;
		logic [QB-1:0] nin_a, nin_b;
		logic gin, nga, ngb;
		logic [SB:0] trl_a, trl_b;
		logic ge_a, ge_b;

		if (j == 0) begin : g_head
			assign rin_a = '0;
			assign rin_b = '0;
			assign nin_a = num_a_s2;
			assign nin_b = num_b_s2;
			assign din_a = dvs_a_s2;
			assign din_b = dvs_b_s2;
			assign nga = neg_a_s2;
			assign ngb = neg_b_s2;
			assign gin = agree_s2;
		end else begin : g_body
			assign rin_a = rem_a_s[j-1];
			assign rin_b = rem_b_s[j-1];
			assign nin_a = num_a_s[j-1];
			assign nin_b = num_b_s[j-1];
			assign din_a = dvs_a_s[j-1];
			assign din_b = dvs_b_s[j-1];
			assign nga = neg_a_s[j-1];
			assign ngb = neg_b_s[j-1];
			assign gin = agree_s[j-1];
		end

		assign trl_a = {rin_a, nin_a[QB-1]};
		assign trl_b = {rin_b, nin_b[QB-1]};
		assign ge_a = (trl_a >= {1'b0, din_a});
		assign ge_b = (trl_b >= {1'b0, din_b});

		always_ff @(posedge clk) begin
			if (en[j+2]) begin
				rem_a_s[j] <= ge_a ? SB'(trl_a - {1'b0, din_a}) : trl_a[SB-1:0];
				rem_b_s[j] <= ge_b ? SB'(trl_b - {1'b0, din_b}) : trl_b[SB-1:0];
				num_a_s[j] <= {nin_a[QB-2:0], ge_a};
				num_b_s[j] <= {nin_b[QB-2:0], ge_b};
				dvs_a_s[j] <= din_a;
				dvs_b_s[j] <= din_b;
				neg_a_s[j] <= nga;
				neg_b_s[j] <= ngb;
				agree_s[j] <= gin;
			end
		end
	end

	// Sign fix: the quotient takes the sign of offset times span, which is a
	// quotient truncated toward zero.
	logic signed [QB:0] pct_a_sx, pct_b_sx;
	logic agree_sx;

	always_ff @(posedge clk) begin
		if (en[QB+2]) begin
			pct_a_sx <= neg_a_s[QB-1] ? -$signed({1'b0, num_a_s[QB-1]})
				: $signed({1'b0, num_a_s[QB-1]});
			pct_b_sx <= neg_b_s[QB-1] ? -$signed({1'b0, num_b_s[QB-1]})
				: $signed({1'b0, num_b_s[QB-1]});
			agree_sx <= agree_s[QB-1];
		end
	end

	// Mean with truncation toward zero: a negative sum gets one added before the
	// arithmetic shift. Then saturation, and zero when the sensors disagree.
	logic signed [QB+1:0] sum_c, adj_c, half_c;
	out_beat_t res_c, res_so;

	always_comb begin
		sum_c = $signed({pct_a_sx[QB], pct_a_sx}) + $signed({pct_b_sx[QB], pct_b_sx});
		adj_c = sum_c + $signed({{(QB+1){1'b0}}, sum_c[QB+1]});
		half_c = adj_c >>> 1;
		res_c.agreement = agree_sx;
		if (!agree_sx) begin
			res_c.throttle_pct = '0;
		end else if (half_c > SUM_MAX) begin
			res_c.throttle_pct = SUM_MAX[OUT_BITS-1:0];
		end else if (half_c < SUM_MIN) begin
			res_c.throttle_pct = SUM_MIN[OUT_BITS-1:0];
		end else begin
			res_c.throttle_pct = half_c[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[QB+3]) begin
			res_so <= res_c;
		end
	end

	assign out_valid = vld_s[NST-1];
	assign out_data = res_so;

	// An empty output stage frees every stage behind it.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output stage is empty");

	// A disagreeing beat always carries zero throttle.
	a_zero_on_disagree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.agreement |-> out_data.throttle_pct == '0)
		else $error("nonzero throttle without agreement");

	// Agreement is only possible with nonzero spans feeding the divider.
	a_agree_needs_span: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] && agree_s2 |-> dvs_a_s2 != '0 && dvs_b_s2 != '0)
		else $error("agreement with a zero span");

	// The final partial remainder is below the divisor for a valid beat in agreement.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QB+1] && agree_s[QB-1]
		|-> rem_a_s[QB-1] < dvs_a_s[QB-1] && rem_b_s[QB-1] < dvs_b_s[QB-1])
		else $error("divider remainder out of range");

endmodule

/* tb/pedal_map_checker.sv */
`timescale 1ns / 1ps

module pedal_map_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dpspm_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [dpspm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  dpspm_pkg::in_beat_t                   in_data,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  dpspm_pkg::out_beat_t                  out_data,
	output int                                    mismatches,
	output int                                    pending,
	output int                                    readouts,
	output int                                    agreed
);
	import dpspm_pkg::*;

	logic [SAMPLE_BITS-1:0] a_lo, a_hi, b_lo, b_hi, win_lo, win_hi;
	logic [RATIO_BITS-1:0] rat_lo, rat_hi;

	out_beat_t expected_readouts[$];

	initial begin
		mismatches = 0;
		pending = 0;
		readouts = 0;
		agreed = 0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch at readout %0d: %s got %0d, expected %0d",
			readouts, what, got, want);
	endtask

	function automatic out_beat_t predict_throttle(input in_beat_t pair);
		longint a, b, pa, pb, mean;
		bit agree;
		out_beat_t r;
		a = longint'(pair.reading_a);
		b = longint'(pair.reading_b);
		agree = (a_hi != a_lo) && (b_hi != b_lo)
			&& (longint'(win_lo) < a) && (a < longint'(win_hi))
			&& (longint'(win_lo) < b) && (b < longint'(win_hi))
			&& (b != 0)
			&& (longint'(rat_lo) * b < (a << RATIO_FRAC))
			&& ((a << RATIO_FRAC) < longint'(rat_hi) * b);
		mean = 0;
		if (agree) begin
			// Signed division truncates toward zero, as the mapping requires.
			pa = (a - longint'(a_lo)) * FULL_SCALE * (longint'(1) << FRAC_BITS_DEF)
				/ (longint'(a_hi) - longint'(a_lo));
			pb = (b - longint'(b_lo)) * FULL_SCALE * (longint'(1) << FRAC_BITS_DEF)
				/ (longint'(b_hi) - longint'(b_lo));
			mean = (pa + pb) / 2;
			if (mean > OUT_MAX)
				mean = OUT_MAX;
			if (mean < OUT_MIN)
				mean = OUT_MIN;
		end
		r.throttle_pct = mean[OUT_BITS-1:0];
		r.agreement = agree;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			a_lo = '0;
			a_hi = '1;
			b_lo = '0;
			b_hi = '1;
			win_lo = '0;
			win_hi = '1;
			rat_lo = '0;
			rat_hi = '1;
			expected_readouts.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
				REG_SENSOR_A_LOW:  a_lo = cfg_wdata[SAMPLE_BITS-1:0];
				REG_SENSOR_A_HIGH: a_hi = cfg_wdata[SAMPLE_BITS-1:0];
				REG_SENSOR_B_LOW:  b_lo = cfg_wdata[SAMPLE_BITS-1:0];
				REG_SENSOR_B_HIGH: b_hi = cfg_wdata[SAMPLE_BITS-1:0];
				REG_WINDOW_LOW:    win_lo = cfg_wdata[SAMPLE_BITS-1:0];
				REG_WINDOW_HIGH:   win_hi = cfg_wdata[SAMPLE_BITS-1:0];
				REG_RATIO_LOW:     rat_lo = cfg_wdata[RATIO_BITS-1:0];
				REG_RATIO_HIGH:    rat_hi = cfg_wdata[RATIO_BITS-1:0];
				default: ;
				endcase
			end
			// Results are matched before this edge's input is queued.
			if (out_valid && out_ready) begin
				readouts++;
				if (expected_readouts.size() == 0) begin
					report_mismatch("readout with nothing outstanding, throttle",
						$signed(out_data.throttle_pct), 0);
				end else begin
					want = expected_readouts.pop_front();
					if (out_data.throttle_pct !== want.throttle_pct)
						report_mismatch("throttle_pct", $signed(out_data.throttle_pct),
							$signed(want.throttle_pct));
					if (out_data.agreement !== want.agreement)
						report_mismatch("agreement", out_data.agreement, want.agreement);
					if (want.agreement)
						agreed++;
				end
			end
			if (in_valid && in_ready)
				expected_readouts.push_back(predict_throttle(in_data));
			pending = expected_readouts.size();
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the pedal plausibility map. All prediction and
// comparison lives in the checker instance; this module only drives beats,
// the register port and the output backpressure.
module tb_top;
	import dpspm_pkg::*;

	// Pipeline depth at the default fraction width is 31 stages, so a
	// little more than that is allowed to flush after the last readout.
	localparam int DRAIN_CYCLES = 48;
	// This leaves a wide margin over a correct run, even with the slowest receiver pace.
	localparam int CYCLE_LIMIT = 400000;
	// Length of the forced receiver hold-off; well past the pipeline depth.
	localparam int LONG_STALL = 240;

	typedef enum logic [1:0] {
		RX_STREAM,
		RX_COIN,
		RX_MOSTLY,
		RX_TRICKLE
	} rx_pace_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;

	int mismatches, pending, readouts, agreed;

	// Window and ratio bounds as currently programmed, used only to shape
	// the random readings so that most of them reach the mapping path.
	int win_lo, win_hi, rat_lo, rat_hi;
	int pairs_offered;
	int settings_loaded;
	int long_stalls_asked;
	int cycle_count;

	dual_pedal_sensor_plausibility_map dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	pedal_map_checker map_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.mismatches(mismatches),
		.pending(pending),
		.readouts(readouts),
		.agreed(agreed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver. It changes pace at random between always ready, a coin toss,
	// mostly ready and a slow trickle. When the stimulus asks for a long
	// stall it holds ready low through a forced hold-off, counted here, so
	// the pipeline fills and the block has to push back on input.
	initial begin : receiver
		rx_pace_t pace;
		int pace_left;
		int hold_left;
		int stalls_served;
		pace = RX_STREAM;
		pace_left = 0;
		hold_left = 0;
		stalls_served = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stalls_served != long_stalls_asked) begin
				stalls_served = long_stalls_asked;
				hold_left = LONG_STALL;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (pace_left == 0) begin
					pace = rx_pace_t'($urandom_range(3, 0));
					pace_left = $urandom_range(150, 20);
				end
				pace_left--;
				case (pace)
				RX_STREAM:  out_ready <= 1'b1;
				RX_COIN:    out_ready <= 1'($urandom_range(1, 0));
				RX_MOSTLY:  out_ready <= ($urandom_range(3, 0) != 0);
				RX_TRICKLE: out_ready <= ($urandom_range(3, 0) == 0);
				default:    out_ready <= 1'b1;
				endcase
			end
		end
	end

	// One beat: raise valid with the pair at the falling edge and keep it
	// until a rising edge sees ready. A back-to-back beat simply re-drives
	// valid high at the next falling edge, so it is never dropped in between.
	task automatic offer_pair(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{reading_a: a, reading_b: b};
		do
			@(posedge clk);
		while (!in_ready);
		pairs_offered++;
	endtask

	task automatic hold_back(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Stop offering and wait until every predicted readout has come back.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
	endtask

	// Writes all eight registers back to back. Sample registers only keep
	// their low 12 bits, so callers may pass junk in the top nibble.
	task automatic load_settings(
		input logic [CFG_DATA_W-1:0] a_low, input logic [CFG_DATA_W-1:0] a_high,
		input logic [CFG_DATA_W-1:0] b_low, input logic [CFG_DATA_W-1:0] b_high,
		input logic [CFG_DATA_W-1:0] w_low, input logic [CFG_DATA_W-1:0] w_high,
		input logic [CFG_DATA_W-1:0] r_low, input logic [CFG_DATA_W-1:0] r_high);
		write_reg(REG_SENSOR_A_LOW, a_low);
		write_reg(REG_SENSOR_A_HIGH, a_high);
		write_reg(REG_SENSOR_B_LOW, b_low);
		write_reg(REG_SENSOR_B_HIGH, b_high);
		write_reg(REG_WINDOW_LOW, w_low);
		write_reg(REG_WINDOW_HIGH, w_high);
		write_reg(REG_RATIO_LOW, r_low);
		write_reg(REG_RATIO_HIGH, r_high);
		@(negedge clk);
		cfg_we <= 1'b0;
		win_lo = int'(w_low[SAMPLE_BITS-1:0]);
		win_hi = int'(w_high[SAMPLE_BITS-1:0]);
		rat_lo = int'(r_low);
		rat_hi = int'(r_high);
		settings_loaded++;
	endtask

	// Most pairs are plausible on purpose: both readings inside the window
	// and, where the ratio band is narrow, a tracking b scaled by the middle
	// of the band with a few counts of noise so the ratio edges get hit.
	// One pair in four is fully random, which also exercises every bit.
	function automatic in_beat_t shaped_pair();
		int lo, hi, mid, bmax, a, b;
		in_beat_t p;
		lo = win_lo + 1;
		hi = win_hi - 1;
		if ($urandom_range(3, 0) == 0 || hi < lo) begin
			p.reading_a = SAMPLE_BITS'($urandom);
			p.reading_b = SAMPLE_BITS'($urandom);
			return p;
		end
		if (rat_hi <= rat_lo || rat_hi - rat_lo > 1024) begin
			a = $urandom_range(hi, lo);
			b = $urandom_range(hi, lo);
		end else begin
			mid = (rat_lo + rat_hi) / 2;
			if (mid == 0)
				mid = 1;
			bmax = (4095 * 256) / mid;
			if (bmax > hi)
				bmax = hi;
			if (bmax < lo)
				bmax = lo;
			b = $urandom_range(bmax, lo);
			a = ((b * mid) >> 8) + int'($urandom_range(12, 0)) - 6;
			if (a < 0)
				a = 0;
			if (a > 4095)
				a = 4095;
		end
		p.reading_a = SAMPLE_BITS'(a);
		p.reading_b = SAMPLE_BITS'(b);
		return p;
	endfunction

	// Random pairs in bursts with random gaps. With a long stall requested,
	// a quarter of the way in the receiver is told to hold off while the
	// sender keeps a long gapless burst going into the full pipeline.
	task automatic stream_pairs(input int count, input bit with_long_stall);
		int burst_left;
		int i;
		in_beat_t p;
		burst_left = $urandom_range(40, 1);
		for (i = 0; i < count; i++) begin
			if (with_long_stall && i == count / 4) begin
				long_stalls_asked++;
				burst_left = 160;
			end
			if (burst_left == 0) begin
				hold_back($urandom_range(12, 1));
				burst_left = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(40, 1);
			end
			p = shaped_pair();
			offer_pair(p.reading_a, p.reading_b);
			burst_left--;
		end
		wait_drained();
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		pairs_offered = 0;
		settings_loaded = 0;
		long_stalls_asked = 0;
		win_lo = 0;
		win_hi = 4095;
		rat_lo = 0;
		rat_hi = 65535;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: full spans, widest window and ratio band. Covers
		// the reading extremes, a zero b reading and the ratio ceiling,
		// where 255/1 just fits below the top bound and 256/1 does not.
		offer_pair(12'd0, 12'd0);
		offer_pair(12'd4095, 12'd4095);
		offer_pair(12'd1, 12'd1);
		offer_pair(12'd4094, 12'd4094);
		offer_pair(12'd2048, 12'd0);
		offer_pair(12'd0, 12'd2048);
		offer_pair(12'd4094, 12'd1);
		offer_pair(12'd255, 12'd1);
		offer_pair(12'd256, 12'd1);
		offer_pair(12'hAAA, 12'h555);
		offer_pair(12'h555, 12'hAAA);
		offer_pair(12'hFFF, 12'h800);
		offer_pair(12'd1, 12'd4094);
		stream_pairs(150, 1'b0);

		// Typical matched sensors with a narrow ratio band. The directed
		// pairs sit on both window bounds and both ratio bounds, one count
		// in and one count out. The long receiver stall happens here.
		load_settings(16'd300, 16'd3800, 16'd300, 16'd3800,
			16'd200, 16'd3900, 16'h00E0, 16'h0120);
		offer_pair(12'd200, 12'd200);
		offer_pair(12'd201, 12'd201);
		offer_pair(12'd3899, 12'd3899);
		offer_pair(12'd3900, 12'd3900);
		offer_pair(12'd224, 12'd256);
		offer_pair(12'd225, 12'd256);
		offer_pair(12'd287, 12'd256);
		offer_pair(12'd288, 12'd256);
		stream_pairs(350, 1'b1);

		// Sensor B wired inverted: its high count maps to zero percent.
		load_settings(16'd400, 16'd3700, 16'd3700, 16'd400,
			16'd0, 16'd4095, 16'h0000, 16'hFFFF);
		stream_pairs(250, 1'b0);

		// Sensor B at half the gain of A, ratio band around two.
		load_settings(16'd100, 16'd4000, 16'd50, 16'd2000,
			16'd0, 16'd4095, 16'h01C0, 16'h0240);
		stream_pairs(250, 1'b0);

		// One-count spans blow the percentage far out of range, so the
		// mean saturates at both ends of the Q8.8 output.
		load_settings(16'd2047, 16'd2048, 16'd2047, 16'd2048,
			16'd0, 16'd4095, 16'h0000, 16'hFFFF);
		offer_pair(12'd1, 12'd1);
		offer_pair(12'd4094, 12'd4094);
		offer_pair(12'd2047, 12'd2047);
		offer_pair(12'd2048, 12'd2048);
		stream_pairs(120, 1'b0);

		// Zero span on sensor A: nothing may ever agree.
		load_settings(16'd1234, 16'd1234, 16'd0, 16'd4095,
			16'd0, 16'd4095, 16'h0000, 16'hFFFF);
		offer_pair(12'd2000, 12'd2000);
		stream_pairs(40, 1'b0);

		// Window with no room between its bounds.
		load_settings(16'd0, 16'd4095, 16'd0, 16'd4095,
			16'd2000, 16'd2001, 16'h0000, 16'hFFFF);
		offer_pair(12'd2000, 12'd2000);
		offer_pair(12'd2001, 12'd2001);
		stream_pairs(40, 1'b0);

		// Ratio bounds crossed over, so the ratio test can never pass.
		load_settings(16'd0, 16'd4095, 16'd0, 16'd4095,
			16'd0, 16'd4095, 16'hFFFF, 16'h0000);
		stream_pairs(40, 1'b0);

		// Upper nibble set on every sample register; only the low 12 bits
		// count, giving spans 100..3840 and 32..3712 and a full window.
		load_settings(16'hF064, 16'hAF00, 16'h5020, 16'h7E80,
			16'h8000, 16'hFFFF, 16'h0080, 16'h0200);
		stream_pairs(250, 1'b1);

		// A few random settings, spans sometimes inverted, junk in the
		// unused register bits.
		for (k = 0; k < 4; k++) begin
			if ($urandom_range(1, 0))
				load_settings({4'($urandom), 12'($urandom_range(1500, 0))},
					{4'($urandom), 12'($urandom_range(4095, 2500))},
					{4'($urandom), 12'($urandom_range(1500, 0))},
					{4'($urandom), 12'($urandom_range(4095, 2500))},
					{4'($urandom), 12'($urandom_range(300, 0))},
					{4'($urandom), 12'($urandom_range(4095, 3700))},
					16'($urandom_range(256, 0)), 16'($urandom_range(1024, 256)));
			else
				load_settings({4'($urandom), 12'($urandom_range(4095, 2500))},
					{4'($urandom), 12'($urandom_range(1500, 0))},
					{4'($urandom), 12'($urandom_range(1500, 0))},
					{4'($urandom), 12'($urandom_range(4095, 2500))},
					{4'($urandom), 12'($urandom_range(300, 0))},
					{4'($urandom), 12'($urandom_range(4095, 3700))},
					16'($urandom_range(256, 0)), 16'($urandom_range(1024, 256)));
			stream_pairs(80, 1'b0);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d sensor pairs under %0d register settings plus reset values,",
			pairs_offered, settings_loaded);
		$display("with %0d readouts checked and %0d of them in agreement.", readouts, agreed);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/dpspm_pkg.sv
rtl/dual_pedal_sensor_plausibility_map.sv
tb/pedal_map_checker.sv
tb/tb_top.sv
